FILE: design/cld_pkg.sv
// shared types, codes and init tables for the character lcd nibble bus controller
package cld_pkg;

  localparam int MAX_BUSY_READS_DEF = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [2:0] {
    CMD_INIT       = 3'd0,
    CMD_WRITE_INSTR = 3'd1,
    CMD_WRITE_DATA = 3'd2,
    CMD_READ_DATA  = 3'd3,
    CMD_SET_CURSOR = 3'd4,
    CMD_BUS_NIBBLE = 3'd5,
    CMD_DETECT     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_STROBE = 2'd1,
    ACT_READY  = 2'd2
  } action_t;

  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;
  localparam logic [7:0] INIT_TAIL_BYTE = 8'h03;

  // one queued unit of bus work, expanded by the back end in this order:
  // init writes, read byte ready, byte write, read strobe
  typedef struct packed {
    logic       do_init;
    logic       do_ready;
    logic       ready_rs;
    logic [7:0] ready_byte;
    logic       ready_tmo;
    logic       do_write;
    logic [7:0] write_byte;
    logic       write_rs;
    logic       do_strobe;
    logic       strobe_rs;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
    job_t head;
  } queue_stat_t;

  function automatic logic [7:0] init_byte(input logic [2:0] sel);
    logic [7:0] b;
    unique case (sel)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h2B;
      3'd2:    b = 8'h2B;
      3'd3:    b = 8'h0C;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      default: b = 8'h1F;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] init_wait(input logic [2:0] sel);
    logic [15:0] w;
    unique case (sel)
      3'd0:    w = 16'd40000;
      3'd1:    w = 16'd39;
      3'd2:    w = 16'd39;
      3'd3:    w = 16'd37;
      3'd4:    w = 16'd37;
      3'd5:    w = 16'd1530;
      default: w = 16'd37;
    endcase
    return w;
  endfunction

endpackage

FILE: design/char_lcd_nibble_bus_controller_top.sv
// top level of the character lcd nibble bus controller
// Accepts one command or sampled bus nibble per cycle as long as the four-entry job queue has
// room; the back end then emits one bus action per cycle while the output is not stalled, so
// an item yields one result per bus action: 15 for init, 3 for a byte write, 4 at the end of
// the init poll, 2 at the end of a data read and 1 otherwise, and commands that cause nothing
// take no back end time. Results leave through a registered stage with tlast on the final one
// of each item. There is no clearing pass after reset.
module char_lcd_nibble_bus_controller_top #(
  parameter int MAX_BUSY_READS = cld_pkg::MAX_BUSY_READS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // command
  input  logic [23:0] in_tdata,   // byte_value, column, row, bus_nibble, detect_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // action
  output logic [31:0] out_tdata,  // register_select, nibble_out, wait_before_us,
                                  // read_byte, busy_timeout
  output logic        out_tlast
);
  import cld_pkg::*;

  push_t       q_push;
  queue_stat_t q_stat;
  logic        pop;

  cld_front #(
    .MAX_BUSY_READS(MAX_BUSY_READS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  cld_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_push(q_push),
    .pop   (pop),
    .q_stat(q_stat)
  );

  cld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

FILE: design/cld_front.sv
// front end: accepts commands, tracks bus state and queues bus jobs
module cld_front #(
  parameter int MAX_BUSY_READS = cld_pkg::MAX_BUSY_READS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [2:0]         in_tuser,   // command
  input  logic [23:0]        in_tdata,   // byte_value, column, row, bus_nibble, detect_level
  input  cld_pkg::queue_stat_t q_stat,
  output cld_pkg::push_t     q_push
);
  import cld_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_POLL  = 2'd1,
    PH_DREAD = 2'd2
  } phase_t;

  localparam logic [3:0] MAX_READS = 4'(MAX_BUSY_READS);

  phase_t     phase_r, phase_nxt;
  logic [1:0] init_step_r, init_step_nxt;
  logic       half_r, half_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [3:0] poll_cnt_r, poll_cnt_nxt;
  logic       det_prev_r, det_prev_nxt;

  logic       accept;
  cmd_t       cmd;
  logic [7:0] byte_value;
  logic [5:0] column;
  logic [1:0] row;
  logic [3:0] nib;
  logic       det;
  logic [7:0] acc_full;
  logic [3:0] cnt_inc;
  logic [7:0] cursor_byte;
  job_t       job;
  logic       job_valid;

  assign in_tready  = !q_stat.full;
  assign accept     = in_tvalid && in_tready;
  assign cmd        = cmd_t'(in_tuser);
  assign byte_value = in_tdata[7:0];
  assign column     = in_tdata[13:8];
  assign row        = in_tdata[15:14];
  assign nib        = in_tdata[19:16];
  assign det        = in_tdata[20];
  assign acc_full   = {acc_r[7:4], nib};
  assign cnt_inc    = poll_cnt_r + 4'd1;
  assign cursor_byte = (row[0] ? ROW1_BASE : ROW0_BASE) + {2'b00, column};

  always_comb begin
    phase_nxt     = phase_r;
    init_step_nxt = init_step_r;
    half_nxt      = half_r;
    acc_nxt       = acc_r;
    poll_cnt_nxt  = poll_cnt_r;
    det_prev_nxt  = det_prev_r;
    job           = '0;
    job_valid     = 1'b0;
    if (accept) begin
      unique case (cmd)
        CMD_INIT, CMD_DETECT: begin
          if (cmd == CMD_INIT || (det && !det_prev_r)) begin
            acc_nxt       = '0;
            init_step_nxt = 2'd1;
            phase_nxt     = PH_POLL;
            half_nxt      = 1'b0;
            poll_cnt_nxt  = '0;
            job.do_init   = 1'b1;
            job.do_strobe = 1'b1;
            job_valid     = 1'b1;
          end
          if (cmd == CMD_DETECT) begin
            det_prev_nxt = det;
          end
        end
        CMD_WRITE_INSTR, CMD_WRITE_DATA, CMD_SET_CURSOR: begin
          if (phase_r == PH_IDLE && (cmd != CMD_SET_CURSOR || !row[1])) begin
            phase_nxt      = PH_POLL;
            half_nxt       = 1'b0;
            poll_cnt_nxt   = '0;
            job.do_write   = 1'b1;
            job.write_byte = (cmd == CMD_SET_CURSOR) ? cursor_byte : byte_value;
            job.write_rs   = (cmd == CMD_WRITE_DATA);
            job.do_strobe  = 1'b1;
            job_valid      = 1'b1;
          end
        end
        CMD_READ_DATA: begin
          if (phase_r == PH_IDLE) begin
            phase_nxt     = PH_DREAD;
            half_nxt      = 1'b0;
            job.do_strobe = 1'b1;
            job.strobe_rs = 1'b1;
            job_valid     = 1'b1;
          end
        end
        CMD_BUS_NIBBLE: begin
          if (phase_r != PH_IDLE) begin
            job_valid = 1'b1;
            if (!half_r) begin
              acc_nxt       = {nib, 4'h0};
              half_nxt      = 1'b1;
              job.do_strobe = 1'b1;
              job.strobe_rs = (phase_r == PH_DREAD);
            end else if (phase_r == PH_DREAD) begin
              acc_nxt        = acc_full;
              phase_nxt      = PH_POLL;
              half_nxt       = 1'b0;
              poll_cnt_nxt   = '0;
              job.do_ready   = 1'b1;
              job.ready_rs   = 1'b1;
              job.ready_byte = acc_full;
              job.do_strobe  = 1'b1;
            end else begin
              acc_nxt  = acc_full;
              half_nxt = 1'b0;
              if (acc_full[7] && cnt_inc < MAX_READS) begin
                poll_cnt_nxt  = cnt_inc;
                job.do_strobe = 1'b1;
              end else begin
                job.do_ready   = 1'b1;
                job.ready_byte = acc_full;
                job.ready_tmo  = acc_full[7];
                poll_cnt_nxt   = '0;
                if (init_step_r == 2'd1) begin
                  init_step_nxt  = 2'd2;
                  job.do_write   = 1'b1;
                  job.write_byte = INIT_TAIL_BYTE;
                  job.do_strobe  = 1'b1;
                end else begin
                  init_step_nxt = 2'd0;
                  phase_nxt     = PH_IDLE;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign q_push.push = job_valid;
  assign q_push.job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      init_step_r <= '0;
      half_r      <= 1'b0;
      acc_r       <= '0;
      poll_cnt_r  <= '0;
      det_prev_r  <= 1'b1;
    end else begin
      phase_r     <= phase_nxt;
      init_step_r <= init_step_nxt;
      half_r      <= half_nxt;
      acc_r       <= acc_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
      det_prev_r  <= det_prev_nxt;
    end
  end

endmodule

FILE: design/cld_queue.sv
// short job queue between front and back ends
module cld_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cld_pkg::push_t       q_push,
  input  logic                 pop,
  output cld_pkg::queue_stat_t q_stat
);
  import cld_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      unique case ({q_push.push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: design/cld_back.sv
// back end: expands queued jobs into bus actions, one per cycle while the output is not stalled
module cld_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cld_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [1:0]           out_tuser,  // action
  output logic [31:0]          out_tdata,  // register_select, nibble_out, wait_before_us,
                                           // read_byte, busy_timeout
  output logic                 out_tlast
);
  import cld_pkg::*;

  localparam logic [4:0] IDX_INIT_END = 5'd13;
  localparam logic [4:0] IDX_READY    = 5'd14;
  localparam logic [4:0] IDX_HI       = 5'd15;
  localparam logic [4:0] IDX_LO       = 5'd16;
  localparam logic [4:0] IDX_STROBE   = 5'd17;

  logic       active_r, active_nxt;
  logic [4:0] idx_r, idx_nxt;
  job_t       job_r, job_nxt;

  logic        valid_r;
  action_t     act_r;
  logic        rs_r;
  logic [3:0]  nib_r;
  logic [15:0] wait_r;
  logic [7:0]  rbyte_r;
  logic        tmo_r;
  logic        last_r;

  job_t        job_use;
  logic [4:0]  idx_first, idx_use, idx_next;
  logic        done;
  logic        emit;
  action_t     act_c;
  logic        rs_c;
  logic [3:0]  nib_c;
  logic [15:0] wait_c;
  logic [7:0]  rbyte_c;
  logic        tmo_c;
  logic [7:0]  ibyte;

  assign emit    = (active_r || !q_stat.empty) && (!valid_r || out_tready);
  assign pop     = emit && !active_r;
  assign job_use = active_r ? job_r : q_stat.head;

  always_comb begin
    priority if (q_stat.head.do_init) begin
      idx_first = '0;
    end else if (q_stat.head.do_ready) begin
      idx_first = IDX_READY;
    end else if (q_stat.head.do_write) begin
      idx_first = IDX_HI;
    end else begin
      idx_first = IDX_STROBE;
    end
  end

  assign idx_use = active_r ? idx_r : idx_first;
  assign ibyte   = init_byte(idx_use[3:1]);

  always_comb begin
    idx_next = IDX_STROBE;
    done     = 1'b0;
    priority if (idx_use < IDX_INIT_END) begin
      idx_next = idx_use + 5'd1;
    end else if (idx_use == IDX_INIT_END) begin
      idx_next = IDX_STROBE;
      done     = !job_use.do_strobe;
    end else if (idx_use == IDX_READY) begin
      idx_next = job_use.do_write ? IDX_HI : IDX_STROBE;
      done     = !job_use.do_write && !job_use.do_strobe;
    end else if (idx_use == IDX_HI) begin
      idx_next = IDX_LO;
    end else if (idx_use == IDX_LO) begin
      done = !job_use.do_strobe;
    end else begin
      done = 1'b1;
    end
  end

  always_comb begin
    act_c   = ACT_WRITE;
    rs_c    = 1'b0;
    nib_c   = '0;
    wait_c  = '0;
    rbyte_c = '0;
    tmo_c   = 1'b0;
    priority if (idx_use <= IDX_INIT_END) begin
      nib_c  = idx_use[0] ? ibyte[3:0] : ibyte[7:4];
      wait_c = idx_use[0] ? 16'd0 : init_wait(idx_use[3:1]);
    end else if (idx_use == IDX_READY) begin
      act_c   = ACT_READY;
      rs_c    = job_use.ready_rs;
      rbyte_c = job_use.ready_byte;
      tmo_c   = job_use.ready_tmo;
    end else if (idx_use == IDX_HI) begin
      rs_c  = job_use.write_rs;
      nib_c = job_use.write_byte[7:4];
    end else if (idx_use == IDX_LO) begin
      rs_c  = job_use.write_rs;
      nib_c = job_use.write_byte[3:0];
    end else begin
      act_c = ACT_STROBE;
      rs_c  = job_use.strobe_rs;
    end
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    job_nxt    = job_r;
    if (emit) begin
      active_nxt = !done;
      idx_nxt    = idx_next;
      job_nxt    = job_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (emit) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    job_r <= job_nxt;
    if (emit) begin
      act_r   <= act_c;
      rs_r    <= rs_c;
      nib_r   <= nib_c;
      wait_r  <= wait_c;
      rbyte_r <= rbyte_c;
      tmo_r   <= tmo_c;
      last_r  <= done;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = act_r;
  assign out_tdata  = {2'b00, tmo_r, rbyte_r, wait_r, nib_r, rs_r};
  assign out_tlast  = last_r;

  // a write carries no read byte and no timeout
  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && act_r == ACT_WRITE |-> rbyte_r == '0 && !tmo_r)
    else $error("write result carries read fields");

  // only a read byte ready result can flag a timeout
  a_tmo_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && tmo_r |-> act_r == ACT_READY)
    else $error("timeout on non ready result");

  // a non final result keeps the job open
  a_job_open: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !done |=> active_r && valid_r && !last_r)
    else $error("job closed before its last result");

  // a job is taken from the queue only when the back end is free
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !active_r && !q_stat.empty)
    else $error("pop while busy or empty");

endmodule
